// ===== rtl/pcg32_pkg.sv =====
// pcg32 generator package: constants, controller state, command and status types
// no dependencies; imported by pcg32_ctrl, pcg32_datapath and the top level
`timescale 1ns / 1ps

package pcg32_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_VALUE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_SELECT = 2'd1;

    localparam logic [31:0] LCG_MULT_LO = 32'h4C95_7F2D;
    localparam logic [31:0] LCG_MULT_HI = 32'h5851_F42D;

    localparam logic [4:0] DIV_LAST_BIT = 5'd31;

    typedef enum logic [1:0] {
        KIND_RAW      = 2'd0,
        KIND_RANGED   = 2'd1,
        KIND_FRACTION = 2'd2,
        KIND_RESEED   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RESEED_INIT,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_ACC_LH,
        ST_UPDATE,
        ST_SEED_ADD,
        ST_DIV_INIT,
        ST_DIV,
        ST_RESULT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_LO_LO,
        MUL_HI_LO,
        MUL_LO_HI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD_HI
    } acc_op_t;

    typedef enum logic [1:0] {
        LCG_HOLD,
        LCG_ADVANCE,
        LCG_CLEAR,
        LCG_ADD_SEED
    } lcg_op_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        lcg_op_t  lcg_op;
        logic     div_init;
        logic     div_step;
        logic     res_load;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  range_empty;
        logic  div_last;
        logic  out_free;
    } dp_status_t;

    // xsh-rr output permutation of one lcg state
    function automatic logic [31:0] pcg_permute(input logic [63:0] prev);
        logic [63:0] xs;
        logic [31:0] mixed;
        logic [63:0] twice;
        xs    = (prev >> 18) ^ prev;
        mixed = xs[58:27];
        twice = {mixed, mixed} >> prev[63:59];
        return twice[31:0];
    endfunction

endpackage

// ===== rtl/pcg32_ctrl.sv =====
// pcg32 controller: sequences multiply, state update, remainder and result load
// depends on pcg32_pkg; drives the command struct of pcg32_datapath
`timescale 1ns / 1ps

module pcg32_ctrl
    import pcg32_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        pass_reg, pass_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        pass_next    = pass_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = MUL_LO_LO;
        cmd.acc_op   = ACC_NONE;
        cmd.lcg_op   = LCG_HOLD;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                pass_next = 1'b0;
                if (status.kind == KIND_RESEED) begin
                    state_next = ST_RESEED_INIT;
                end else if (status.kind == KIND_RANGED && status.range_empty) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_MUL_LL;
                end
            end
            ST_RESEED_INIT: begin
                cmd.lcg_op = LCG_CLEAR;
                state_next = ST_MUL_LL;
            end
            ST_MUL_LL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO_LO;
                state_next  = ST_MUL_HL;
            end
            ST_MUL_HL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HI_LO;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL_LH;
            end
            ST_MUL_LH: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LO_HI;
                cmd.acc_op  = ACC_ADD_HI;
                state_next  = ST_ACC_LH;
            end
            ST_ACC_LH: begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.lcg_op = LCG_ADVANCE;
                if (status.kind == KIND_RESEED && !pass_reg) begin
                    pass_next  = 1'b1;
                    state_next = ST_SEED_ADD;
                end else if (status.kind == KIND_RANGED) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SEED_ADD: begin
                cmd.lcg_op = LCG_ADD_SEED;
                state_next = ST_MUL_LL;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_result_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> status.out_free)
        else $error("result loaded while output register still held");

    a_accept_goes_to_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted transaction not decoded");

    a_seed_add_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED_ADD) |-> (pass_reg && status.kind == KIND_RESEED))
        else $error("seed added outside first reseed pass");

endmodule

// ===== rtl/pcg32_datapath.sv =====
// pcg32 datapath: lcg state, shared 32x32 multiplier, bit-serial remainder, output register
// depends on pcg32_pkg; commanded by pcg32_ctrl
`timescale 1ns / 1ps

module pcg32_datapath
    import pcg32_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [1:0]             s_kind,
    input  logic signed [31:0]     s_range_low,
    input  logic signed [31:0]     s_range_high,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_draw,
    output logic signed [31:0]     m_ranged,
    output logic [23:0]            m_fraction
);

    logic [63:0]        lcg_state_reg;
    logic [63:0]        inc_reg;
    logic [63:0]        seed_reg;
    logic [62:0]        stream_reg;
    kind_t              kind_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic [31:0]        draw_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dvd_reg;
    logic [4:0]         cnt_reg;
    logic               m_valid_reg;
    logic [31:0]        m_draw_reg;
    logic [31:0]        m_ranged_reg;
    logic [23:0]        m_fraction_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_full;
    logic [31:0] span;
    logic [32:0] trial;
    logic [31:0] rem_next;

    assign span = hi_reg - lo_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg   <= '0;
            stream_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_SEED_VALUE) begin
                seed_reg <= cfg_wdata;
            end else if (cfg_index == CFG_STREAM_SELECT) begin
                stream_reg <= cfg_wdata[62:0];
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= kind_t'(s_kind);
            lo_reg   <= s_range_low;
            hi_reg   <= s_range_high;
        end
    end

    // shared multiplier, one partial product per cycle
    always_comb begin
        case (cmd.mul_sel)
            MUL_LO_LO: begin
                mul_a = lcg_state_reg[31:0];
                mul_b = LCG_MULT_LO;
            end
            MUL_HI_LO: begin
                mul_a = lcg_state_reg[63:32];
                mul_b = LCG_MULT_LO;
            end
            MUL_LO_HI: begin
                mul_a = lcg_state_reg[31:0];
                mul_b = LCG_MULT_HI;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_full;
        end
        case (cmd.acc_op)
            ACC_LOAD:   acc_reg <= prod_reg;
            ACC_ADD_HI: acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
            default:    acc_reg <= acc_reg;
        endcase
    end

    // lcg state and increment
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_state_reg <= '0;
            inc_reg       <= 64'd1;
        end else begin
            case (cmd.lcg_op)
                LCG_ADVANCE: lcg_state_reg <= acc_reg + inc_reg;
                LCG_CLEAR: begin
                    lcg_state_reg <= '0;
                    inc_reg       <= {stream_reg, 1'b1};
                end
                LCG_ADD_SEED: lcg_state_reg <= lcg_state_reg + seed_reg;
                default:      lcg_state_reg <= lcg_state_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lcg_op == LCG_ADVANCE) begin
            draw_reg <= pcg_permute(lcg_state_reg);
        end
    end

    // restoring remainder, one dividend bit per cycle
    assign trial    = {rem_reg, dvd_reg[31]};
    assign rem_next = (trial >= {1'b0, span}) ? 32'(trial - {1'b0, span}) : trial[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= '0;
            dvd_reg <= draw_reg;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (kind_reg)
                KIND_RAW: begin
                    m_draw_reg     <= draw_reg;
                    m_ranged_reg   <= '0;
                    m_fraction_reg <= '0;
                end
                KIND_RANGED: begin
                    m_fraction_reg <= '0;
                    if (status.range_empty) begin
                        m_draw_reg   <= '0;
                        m_ranged_reg <= lo_reg;
                    end else begin
                        m_draw_reg   <= draw_reg;
                        m_ranged_reg <= lo_reg + rem_reg;
                    end
                end
                KIND_FRACTION: begin
                    m_draw_reg     <= draw_reg;
                    m_ranged_reg   <= '0;
                    m_fraction_reg <= draw_reg[31:8];
                end
                default: begin
                    m_draw_reg     <= '0;
                    m_ranged_reg   <= '0;
                    m_fraction_reg <= '0;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_draw     = m_draw_reg;
    assign m_ranged   = m_ranged_reg;
    assign m_fraction = m_fraction_reg;

    assign status.kind        = kind_reg;
    assign status.range_empty = (hi_reg <= lo_reg);
    assign status.div_last    = (cnt_reg == DIV_LAST_BIT);
    assign status.out_free    = !m_valid_reg || m_ready;

    a_increment_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        inc_reg[0])
        else $error("lcg increment became even");

    a_remainder_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < span))
        else $error("partial remainder not below span");

    a_step_needs_span: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |-> (!status.range_empty && span != 32'd0))
        else $error("remainder started on empty range");

endmodule

// ===== rtl/pcg32_random_generator_top.sv =====
// pcg32 xsh-rr 64/32 generator for raw, fraction, ranged and reseed transactions; result valid
// and ready return at the same edge; the 64-bit state update takes three passes through one
// 32x32 multiplier, the ranged remainder one bit per cycle over all 32 dividend bits; one
// transaction in flight
// synchronous active-low reset: state 0, increment 1, seed and stream 0, no result held
`timescale 1ns / 1ps

module pcg32_random_generator_top
    import pcg32_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic signed [31:0]     s_range_low,
    input  logic signed [31:0]     s_range_high,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_draw,
    output logic signed [31:0]     m_ranged,
    output logic [23:0]            m_fraction
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pcg32_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pcg32_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_kind       (s_kind),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_draw       (m_draw),
        .m_ranged     (m_ranged),
        .m_fraction   (m_fraction)
    );

endmodule

// ===== tb/pcg32_draw_checker.sv =====
// draw checker for the pcg32 xsh-rr 64/32 generator: tracks register writes and
// input transactions, predicts each result and compares it field by field
// depends on pcg32_pkg for the kind codes and register indexes
`timescale 1ns / 1ps

module pcg32_draw_checker
    import pcg32_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic signed [31:0]     s_range_low,
    input  logic signed [31:0]     s_range_high,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [31:0]            m_draw,
    input  logic signed [31:0]     m_ranged,
    input  logic [23:0]            m_fraction,
    output int                     mismatches,
    output int                     outstanding,
    output int                     checked
);

    localparam logic [63:0] LCG_MULTIPLIER = 64'h5851_F42D_4C95_7F2D;

    typedef struct packed {
        logic [31:0] draw;
        logic [31:0] ranged;
        logic [23:0] fraction;
    } draw_fields_t;

    logic [63:0]  gen_state = 64'd0;
    logic [63:0]  gen_inc = 64'd1;
    logic [63:0]  seed_reg = 64'd0;
    logic [62:0]  stream_reg = 63'd0;
    draw_fields_t expected_draws[$];

    initial begin
        mismatches = 0;
        outstanding = 0;
        checked = 0;
    end

    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [63:0] folded;
        logic [31:0] word;
        logic [4:0]  rot;
        folded = ((old >> 18) ^ old) >> 27;
        word   = folded[31:0];
        rot    = old[63:59];
        return (word >> rot) | (word << (6'd32 - {1'b0, rot}));
    endfunction

    task automatic advance_gen(output logic [31:0] word);
        logic [63:0] old;
        old = gen_state;
        gen_state = old * LCG_MULTIPLIER + gen_inc;
        word = xsh_rr(old);
    endtask

    task automatic report_error(input string msg);
        $display("[%0t] checker: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic predict_draw(input kind_t k, input logic signed [31:0] lo,
                                input logic signed [31:0] hi);
        draw_fields_t want;
        logic [31:0]  word;
        logic [31:0]  span;
        want = '0;
        case (k)
            KIND_RAW: begin
                advance_gen(word);
                want.draw = word;
            end
            KIND_RANGED: begin
                if (hi > lo) begin
                    span = hi - lo;
                    advance_gen(word);
                    want.draw = word;
                    want.ranged = lo + (word % span);
                end else begin
                    want.ranged = lo;
                end
            end
            KIND_FRACTION: begin
                advance_gen(word);
                want.draw = word;
                want.fraction = word[31:8];
            end
            default: begin
                gen_state = 64'd0;
                gen_inc = {stream_reg, 1'b1};
                advance_gen(word);
                gen_state = gen_state + seed_reg;
                advance_gen(word);
            end
        endcase
        expected_draws.push_back(want);
    endtask

    always @(posedge aclk) begin
        draw_fields_t want;
        if (!aresetn) begin
            gen_state = 64'd0;
            gen_inc = 64'd1;
            seed_reg = 64'd0;
            stream_reg = 63'd0;
            expected_draws.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SEED_VALUE: seed_reg = cfg_wdata;
                    CFG_STREAM_SELECT: stream_reg = cfg_wdata[62:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_draw(kind_t'(s_kind), s_range_low, s_range_high);
            if (m_valid && m_ready) begin
                if (expected_draws.size() == 0) begin
                    report_error($sformatf("unexpected transaction draw=%h ranged=%h fraction=%h",
                                           m_draw, m_ranged, m_fraction));
                end else begin
                    want = expected_draws.pop_front();
                    if (m_draw !== want.draw)
                        report_error($sformatf("draw got %h want %h", m_draw, want.draw));
                    if (m_ranged !== want.ranged)
                        report_error($sformatf("ranged got %h want %h", m_ranged, want.ranged));
                    if (m_fraction !== want.fraction)
                        report_error($sformatf("fraction got %h want %h",
                                               m_fraction, want.fraction));
                    checked++;
                end
            end
        end
        outstanding = expected_draws.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for pcg32_random_generator_top: clock, reset, register writes,
// directed and random request transactions with idle patterns and back-pressure
// depends on pcg32_pkg, the generator rtl and pcg32_draw_checker
`timescale 1ns / 1ps

module tb;
    import pcg32_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int LONG_STALL     = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 60;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_kind = KIND_RAW;
    logic signed [31:0]     s_range_low = '0;
    logic signed [31:0]     s_range_high = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [31:0]            m_draw;
    logic signed [31:0]     m_ranged;
    logic [23:0]            m_fraction;

    int mismatches;
    int outstanding;
    int checked;

    int snd_idle_pct = 37;
    int rcv_idle_pct = 81;
    int stall_requests = 0;
    int stall_served = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int kind_tally[4] = '{0, 0, 0, 0};
    int empty_ranges = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pcg32_random_generator_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_draw       (m_draw),
        .m_ranged     (m_ranged),
        .m_fraction   (m_fraction)
    );

    pcg32_draw_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_draw       (m_draw),
        .m_ranged     (m_ranged),
        .m_fraction   (m_fraction),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked)
    );

    // result side: random idling plus long hold-offs on request
    always @(negedge aclk) begin
        if (stall_served != stall_requests) begin
            stall_left = LONG_STALL;
            stall_served = stall_requests;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic set_idle(input int pattern);
        case (pattern)
            0: begin
                snd_idle_pct = 37;
                rcv_idle_pct = 81;
            end
            1: begin
                snd_idle_pct = 81;
                rcv_idle_pct = 37;
            end
            default: begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input kind_t k, input logic signed [31:0] lo,
                                input logic signed [31:0] hi);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_range_low <= lo;
        s_range_high <= hi;
        do @(posedge aclk); while (!s_ready);
        kind_tally[k]++;
        if (k == KIND_RANGED && hi <= lo)
            empty_ranges++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0 || !s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_random_request();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] tmp;
        int pick;
        kind_t k;
        lo = $urandom;
        hi = $urandom;
        pick = $urandom_range(99);
        if (pick < 25)
            k = KIND_RAW;
        else if (pick < 65)
            k = KIND_RANGED;
        else if (pick < 90)
            k = KIND_FRACTION;
        else
            k = KIND_RESEED;
        if (k == KIND_RANGED) begin
            case ($urandom_range(3))
                0: ;
                1: hi = lo + 32'($urandom_range(16, 1));
                2: begin
                    if (lo > hi) begin
                        tmp = lo;
                        lo = hi;
                        hi = tmp;
                    end
                end
                default: hi = lo - 32'($urandom_range(5));
            endcase
        end
        send_request(k, lo, hi);
    endtask

    initial begin
        logic [63:0] seed_val;
        logic [63:0] stream_val;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_idle(0);

        // directed: field extremes, every kind, empty ranges, unused bounds
        send_request(KIND_RAW, INT_MIN, INT_MAX);
        send_request(KIND_FRACTION, INT_MAX, INT_MIN);
        send_request(KIND_RANGED, INT_MIN, INT_MAX);
        send_request(KIND_RANGED, 32'sd0, 32'sd1);
        send_request(KIND_RANGED, 32'sd5, 32'sd5);
        send_request(KIND_RANGED, 32'sd10, -32'sd10);
        send_request(KIND_RANGED, INT_MAX, INT_MIN);
        send_request(KIND_RANGED, INT_MIN, 32'sd0);
        send_request(KIND_RANGED, -32'sd1, 32'sd0);
        send_request(KIND_RANGED, 32'sd0, INT_MAX);
        send_request(KIND_RANGED, INT_MAX - 32'sd1, INT_MAX);
        send_request(KIND_RANGED, -32'sd7, 32'sd9);
        send_request(KIND_RESEED, -32'sd1, -32'sd1);
        send_request(KIND_RAW, 32'sd0, 32'sd0);
        send_request(KIND_FRACTION, $urandom, $urandom);
        send_request(KIND_RANGED, -32'sd100, 32'sd100);
        send_request(KIND_RESEED, $urandom, $urandom);
        send_request(KIND_RANGED, INT_MIN, INT_MIN + 32'sd1);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    seed_val = 64'd0;
                    stream_val = 64'd0;
                end
                1: begin
                    seed_val = '1;
                    stream_val = 64'h7FFF_FFFF_FFFF_FFFF;
                end
                2: begin
                    seed_val = {$urandom, $urandom};
                    stream_val = {1'b1, 31'($urandom), 32'($urandom)};
                end
                3: begin
                    seed_val = {$urandom, $urandom};
                    stream_val = 64'd0;
                end
                4: begin
                    seed_val = 64'd0;
                    stream_val = {$urandom, $urandom};
                end
                default: begin
                    seed_val = {$urandom, $urandom};
                    stream_val = {$urandom, $urandom};
                end
            endcase
            write_reg(CFG_SEED_VALUE, seed_val);
            write_reg(CFG_STREAM_SELECT, stream_val);
            if (phase == 3 || phase == 5) begin
                write_reg(CFG_SPARE_LO, {$urandom, $urandom});
                write_reg(CFG_SPARE_HI, {$urandom, $urandom});
            end
            set_idle(phase / 2);
            send_request(KIND_RESEED, $urandom, $urandom);
            for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
                if (n == 100 && (phase == 1 || phase == 4))
                    stall_requests++;
                if (n == 140 && (phase == 2 || phase == 5)) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                    while (outstanding != 0)
                        @(negedge aclk);
                end
                send_random_request();
            end
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("covered %0d raw, %0d ranged (%0d empty), %0d fraction, %0d reseed transactions",
                 kind_tally[KIND_RAW], kind_tally[KIND_RANGED], empty_ranges,
                 kind_tally[KIND_FRACTION], kind_tally[KIND_RESEED]);
        $display("%0d results compared over %0d register settings and three idle patterns",
                 checked, NUM_PHASES + 1);
        if (mismatches == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
